// ===== sv/reaction_diffusion_line_stencil_top_defines.svh =====
// Assertion macros for the line stencil checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef REACTION_DIFFUSION_LINE_STENCIL_TOP_DEFINES_SVH
`define REACTION_DIFFUSION_LINE_STENCIL_TOP_DEFINES_SVH

// same-cycle implication
`define RDLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RDLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rdls_pkg.sv =====
// Shared constants and types for the reaction-diffusion line stencil.
// No dependencies.
package rdls_pkg;

	localparam int WORD_BITS      = 32;
	localparam int FRAC_BITS      = 24;
	localparam int CFG_BITS       = 31;
	localparam int PROD_BITS      = 2 * WORD_BITS;
	localparam int SHIFT_BITS     = PROD_BITS - FRAC_BITS;
	localparam int NUM_REGS       = 5;
	localparam int REG_INDEX_BITS = $clog2(NUM_REGS);
	localparam int ADDR_BITS      = REG_INDEX_BITS + 2;
	localparam int APB_DATA_BITS  = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [REG_INDEX_BITS-1:0] REG_DIFF_U = REG_INDEX_BITS'(0);
	localparam logic [REG_INDEX_BITS-1:0] REG_DIFF_V = REG_INDEX_BITS'(1);
	localparam logic [REG_INDEX_BITS-1:0] REG_HALF   = REG_INDEX_BITS'(2);
	localparam logic [REG_INDEX_BITS-1:0] REG_FEED_A = REG_INDEX_BITS'(3);
	localparam logic [REG_INDEX_BITS-1:0] REG_FEED_B = REG_INDEX_BITS'(4);

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] diffusion_u;
		logic [CFG_BITS-1:0] diffusion_v;
		logic [CFG_BITS-1:0] half_step;
		logic [CFG_BITS-1:0] feed_a;
		logic [CFG_BITS-1:0] feed_b;
	} cfg_t;

	// one queued job: interior update of c and/or boundary pass of r
	typedef struct packed {
		logic  interior;
		logic  pass;
		logic  last;
		word_t l_u;
		word_t l_v;
		word_t c_u;
		word_t c_v;
		word_t r_u;
		word_t r_v;
	} cmd_t;

endpackage

// ===== sv/rdls_if.sv =====
// Valid/ready stream interfaces for grid samples and results.
// Depends on rdls_pkg.
interface rdls_in_if;
	logic                 valid;
	logic                 ready;
	rdls_pkg::word_t      u_sample;
	rdls_pkg::word_t      v_sample;
	logic                 line_end;

	modport source (output valid, u_sample, v_sample, line_end, input ready);
	modport sink (input valid, u_sample, v_sample, line_end, output ready);
endinterface

interface rdls_out_if;
	logic                 valid;
	logic                 ready;
	rdls_pkg::word_t      u_result;
	rdls_pkg::word_t      v_result;
	logic                 line_last;
	logic                 saturated;

	modport source (output valid, u_result, v_result, line_last, saturated, input ready);
	modport sink (input valid, u_result, v_result, line_last, saturated, output ready);
endinterface

// ===== sv/reaction_diffusion_line_stencil_top.sv =====
// Path: a boundary point goes through the job queue and the PASS state into the
// result register; an interior point, after the transfer of its right neighbor,
// runs through the update states (seven products through one shared 32x32
// multiplier). The engine ends one job before it takes the next; a 2-entry job queue decouples input.
// Reset (arst_n low, asynchronous): registers zero, empty queue, start of line.
module reaction_diffusion_line_stencil_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rdls_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [rdls_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [rdls_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready,
	rdls_in_if.sink                              samples,
	rdls_out_if.source                           results
);

	rdls_pkg::cfg_t                          cfg_q;
	logic [rdls_pkg::REG_INDEX_BITS-1:0]     reg_index;
	logic                                    cfg_write;
	logic                                    q_push, q_full, q_pop, q_nonempty;
	rdls_pkg::cmd_t                          push_cmd, pop_cmd;

	assign pready    = 1'b1;
	assign reg_index = paddr[rdls_pkg::ADDR_BITS-1:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_index)
				rdls_pkg::REG_DIFF_U: cfg_q.diffusion_u <= pwdata[rdls_pkg::CFG_BITS-1:0];
				rdls_pkg::REG_DIFF_V: cfg_q.diffusion_v <= pwdata[rdls_pkg::CFG_BITS-1:0];
				rdls_pkg::REG_HALF:   cfg_q.half_step   <= pwdata[rdls_pkg::CFG_BITS-1:0];
				rdls_pkg::REG_FEED_A: cfg_q.feed_a      <= pwdata[rdls_pkg::CFG_BITS-1:0];
				rdls_pkg::REG_FEED_B: cfg_q.feed_b      <= pwdata[rdls_pkg::CFG_BITS-1:0];
				default: begin end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_index)
			rdls_pkg::REG_DIFF_U: prdata = rdls_pkg::APB_DATA_BITS'(cfg_q.diffusion_u);
			rdls_pkg::REG_DIFF_V: prdata = rdls_pkg::APB_DATA_BITS'(cfg_q.diffusion_v);
			rdls_pkg::REG_HALF:   prdata = rdls_pkg::APB_DATA_BITS'(cfg_q.half_step);
			rdls_pkg::REG_FEED_A: prdata = rdls_pkg::APB_DATA_BITS'(cfg_q.feed_a);
			rdls_pkg::REG_FEED_B: prdata = rdls_pkg::APB_DATA_BITS'(cfg_q.feed_b);
			default: prdata = '0;
		endcase
	end

	rdls_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (push_cmd)
	);

	rdls_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.nonempty (q_nonempty)
	);

	rdls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.q_cmd      (pop_cmd),
		.q_pop      (q_pop),
		.results    (results)
	);

endmodule

// ===== sv/rdls_front.sv =====
// Front end: takes samples, keeps the two-point window, issues jobs to the queue.
// Depends on rdls_pkg and rdls_in_if.
module rdls_front (
	input  logic             clk,
	input  logic             arst_n,
	rdls_in_if.sink          samples,
	input  logic             q_full,
	output logic             q_push,
	output rdls_pkg::cmd_t   q_cmd
);

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;

	logic [1:0]      seen_q;
	rdls_pkg::word_t w0_u_q, w0_v_q, w1_u_q, w1_v_q;
	logic            accept;

	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;

	always_comb begin
		q_cmd.interior = (seen_q == SEEN_TWO);
		q_cmd.pass     = (seen_q == SEEN_NONE) || samples.line_end;
		q_cmd.last     = samples.line_end;
		q_cmd.l_u      = w1_u_q;
		q_cmd.l_v      = w1_v_q;
		q_cmd.c_u      = w0_u_q;
		q_cmd.c_v      = w0_v_q;
		q_cmd.r_u      = samples.u_sample;
		q_cmd.r_v      = samples.v_sample;
	end

	assign q_push = accept && (q_cmd.interior || q_cmd.pass);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
		end else if (accept) begin
			if (samples.line_end) begin
				seen_q <= SEEN_NONE;
			end else begin
				case (seen_q)
					SEEN_NONE: seen_q <= SEEN_ONE;
					default:   seen_q <= SEEN_TWO;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !samples.line_end) begin
			w1_u_q <= w0_u_q;
			w1_v_q <= w0_v_q;
			w0_u_q <= samples.u_sample;
			w0_v_q <= samples.v_sample;
		end
	end

endmodule

// ===== sv/rdls_queue.sv =====
// Short job queue between the front end and the update engine.
// Depends on rdls_pkg.
module rdls_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rdls_pkg::cmd_t   push_cmd,
	output logic             full,
	input  logic             pop,
	output rdls_pkg::cmd_t   pop_cmd,
	output logic             nonempty
);

	localparam logic [rdls_pkg::QPTR_BITS-1:0] PTR_LAST =
		rdls_pkg::QPTR_BITS'(rdls_pkg::QUEUE_DEPTH - 1);
	localparam logic [rdls_pkg::QPTR_BITS:0] COUNT_FULL =
		(rdls_pkg::QPTR_BITS + 1)'(rdls_pkg::QUEUE_DEPTH);

	rdls_pkg::cmd_t                  entries_q [rdls_pkg::QUEUE_DEPTH];
	logic [rdls_pkg::QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [rdls_pkg::QPTR_BITS:0]    count_q;
	logic                            do_push, do_pop;

	assign full     = (count_q == COUNT_FULL);
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign pop_cmd  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== sv/rdls_back.sv =====
// Update engine: runs the stencil update through one shared multiplier and
// holds the result register. Depends on rdls_pkg and rdls_out_if.
module rdls_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rdls_pkg::cfg_t   cfg,
	input  logic             q_nonempty,
	input  rdls_pkg::cmd_t   q_cmd,
	output logic             q_pop,
	rdls_out_if.source       results
);

	localparam int W = rdls_pkg::WORD_BITS;
	localparam rdls_pkg::word_t WORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam rdls_pkg::word_t WORD_MIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic            hit;
		rdls_pkg::word_t val;
	} sat_t;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_LAP  = 14'b00000000000010,
		ST_MDU  = 14'b00000000000100,
		ST_MDV  = 14'b00000000001000,
		ST_MUU  = 14'b00000000010000,
		ST_MBU  = 14'b00000000100000,
		ST_MUUV = 14'b00000001000000,
		ST_WUUV = 14'b00000010000000,
		ST_SUM  = 14'b00000100000000,
		ST_MHU  = 14'b00001000000000,
		ST_MHV  = 14'b00010000000000,
		ST_WHV  = 14'b00100000000000,
		ST_FIN  = 14'b01000000000000,
		ST_PASS = 14'b10000000000000
	} state_t;

	function automatic sat_t clamp_wide(input logic signed [W:0] s);
		sat_t r;
		r.hit = (s[W] != s[W-1]);
		r.val = r.hit ? (s[W] ? WORD_MIN : WORD_MAX) : s[W-1:0];
		return r;
	endfunction

	function automatic sat_t sat_add(input rdls_pkg::word_t a, input rdls_pkg::word_t b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return clamp_wide(s);
	endfunction

	function automatic sat_t sat_sub(input rdls_pkg::word_t a, input rdls_pkg::word_t b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		return clamp_wide(s);
	endfunction

	// floor shift by the fraction width, then clamp to the word range
	function automatic sat_t fix_product(input logic signed [rdls_pkg::PROD_BITS-1:0] p);
		logic [rdls_pkg::SHIFT_BITS-1:0] q;
		sat_t                            r;
		q     = rdls_pkg::SHIFT_BITS'(p >>> rdls_pkg::FRAC_BITS);
		r.hit = !((&q[rdls_pkg::SHIFT_BITS-1:W-1]) || !(|q[rdls_pkg::SHIFT_BITS-1:W-1]));
		r.val = r.hit ? (q[rdls_pkg::SHIFT_BITS-1] ? WORD_MIN : WORD_MAX) : q[W-1:0];
		return r;
	endfunction

	state_t                                   state_q;
	rdls_pkg::cmd_t                           cmd_q;
	logic signed [rdls_pkg::PROD_BITS-1:0]    prod_q;
	rdls_pkg::word_t                          mul_a, mul_b;
	rdls_pkg::word_t                          lap_u_q, lap_v_q, diff_u_q, diff_v_q;
	rdls_pkg::word_t                          uu_q, bu_q, uuv_q, xu_q, xv_q;
	rdls_pkg::word_t                          su_q, sv_q, hu_q, hv_q;
	logic                                     hit_q;
	logic                                     out_valid_q, out_last_q, out_sat_q;
	rdls_pkg::word_t                          out_u_q, out_v_q;
	logic                                     slot_free, load;
	rdls_pkg::word_t                          ru, rv, hh, fa, fb;
	sat_t                                     fixed;
	sat_t                                     rl_u, cc_u, lap_u, rl_v, cc_v, lap_v;
	sat_t                                     a_uuv, b1u, xu, xv, su, sv, res_u, res_v;

	assign ru = rdls_pkg::word_t'({1'b0, cfg.diffusion_u});
	assign rv = rdls_pkg::word_t'({1'b0, cfg.diffusion_v});
	assign hh = rdls_pkg::word_t'({1'b0, cfg.half_step});
	assign fa = rdls_pkg::word_t'({1'b0, cfg.feed_a});
	assign fb = rdls_pkg::word_t'({1'b0, cfg.feed_b});

	assign slot_free = !out_valid_q || results.ready;
	assign load      = slot_free && ((state_q == ST_FIN) || (state_q == ST_PASS));
	assign q_pop     = (state_q == ST_IDLE) && q_nonempty;

	assign results.valid     = out_valid_q;
	assign results.u_result  = out_u_q;
	assign results.v_result  = out_v_q;
	assign results.line_last = out_last_q;
	assign results.saturated = out_sat_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MDU:  begin mul_a = ru;   mul_b = lap_u_q;   end
			ST_MDV:  begin mul_a = rv;   mul_b = lap_v_q;   end
			ST_MUU:  begin mul_a = cmd_q.c_u; mul_b = cmd_q.c_u; end
			ST_MBU:  begin mul_a = fb;   mul_b = cmd_q.c_u; end
			ST_MUUV: begin mul_a = uu_q; mul_b = cmd_q.c_v; end
			ST_MHU:  begin mul_a = hh;   mul_b = xu_q;      end
			ST_MHV:  begin mul_a = hh;   mul_b = xv_q;      end
			default: begin end
		endcase
	end

	always_comb begin
		fixed = fix_product(prod_q);
		rl_u  = sat_add(cmd_q.r_u, cmd_q.l_u);
		cc_u  = sat_add(cmd_q.c_u, cmd_q.c_u);
		lap_u = sat_sub(rl_u.val, cc_u.val);
		rl_v  = sat_add(cmd_q.r_v, cmd_q.l_v);
		cc_v  = sat_add(cmd_q.c_v, cmd_q.c_v);
		lap_v = sat_sub(rl_v.val, cc_v.val);
		a_uuv = sat_add(fa, uuv_q);
		b1u   = sat_add(bu_q, cmd_q.c_u);
		xu    = sat_sub(a_uuv.val, b1u.val);
		xv    = sat_sub(bu_q, uuv_q);
		su    = sat_add(cmd_q.c_u, diff_u_q);
		sv    = sat_add(cmd_q.c_v, diff_v_q);
		res_u = sat_add(su_q, hu_q);
		res_v = sat_add(sv_q, hv_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_nonempty) begin
						state_q <= q_cmd.interior ? ST_LAP : ST_PASS;
					end
				end
				ST_LAP:  state_q <= ST_MDU;
				ST_MDU:  state_q <= ST_MDV;
				ST_MDV:  state_q <= ST_MUU;
				ST_MUU:  state_q <= ST_MBU;
				ST_MBU:  state_q <= ST_MUUV;
				ST_MUUV: state_q <= ST_WUUV;
				ST_WUUV: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_MHU;
				ST_MHU:  state_q <= ST_MHV;
				ST_MHV:  state_q <= ST_WHV;
				ST_WHV:  state_q <= ST_FIN;
				ST_FIN: begin
					if (slot_free) begin
						state_q <= cmd_q.pass ? ST_PASS : ST_IDLE;
					end
				end
				ST_PASS: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath; each product lands in prod_q in the state after the one that selects its operands
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (q_nonempty) begin
					cmd_q <= q_cmd;
					hit_q <= 1'b0;
				end
			end
			ST_LAP: begin
				lap_u_q <= lap_u.val;
				lap_v_q <= lap_v.val;
				hit_q   <= hit_q | rl_u.hit | cc_u.hit | lap_u.hit
				           | rl_v.hit | cc_v.hit | lap_v.hit;
			end
			ST_MDV: begin
				diff_u_q <= fixed.val;
				hit_q    <= hit_q | fixed.hit;
			end
			ST_MUU: begin
				diff_v_q <= fixed.val;
				hit_q    <= hit_q | fixed.hit;
			end
			ST_MBU: begin
				uu_q  <= fixed.val;
				hit_q <= hit_q | fixed.hit;
			end
			ST_MUUV: begin
				bu_q  <= fixed.val;
				hit_q <= hit_q | fixed.hit;
			end
			ST_WUUV: begin
				uuv_q <= fixed.val;
				hit_q <= hit_q | fixed.hit;
			end
			ST_SUM: begin
				xu_q  <= xu.val;
				xv_q  <= xv.val;
				su_q  <= su.val;
				sv_q  <= sv.val;
				hit_q <= hit_q | a_uuv.hit | b1u.hit | xu.hit | xv.hit | su.hit | sv.hit;
			end
			ST_MHV: begin
				hu_q  <= fixed.val;
				hit_q <= hit_q | fixed.hit;
			end
			ST_WHV: begin
				hv_q  <= fixed.val;
				hit_q <= hit_q | fixed.hit;
			end
			ST_FIN: begin
				if (slot_free) begin
					out_u_q    <= res_u.val;
					out_v_q    <= res_v.val;
					out_last_q <= 1'b0;
					out_sat_q  <= hit_q | res_u.hit | res_v.hit;
				end
			end
			ST_PASS: begin
				if (slot_free) begin
					out_u_q    <= cmd_q.r_u;
					out_v_q    <= cmd_q.r_v;
					out_last_q <= cmd_q.last;
					out_sat_q  <= 1'b0;
				end
			end
			default: begin end
		endcase
	end

endmodule

// ===== sv/rdls_checker.sv =====
// Port-level checks for the line stencil top, attached by bind.
// Depends on rdls_pkg and reaction_diffusion_line_stencil_top_defines.svh.
`include "reaction_diffusion_line_stencil_top_defines.svh"

module rdls_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input rdls_pkg::word_t                     u_result,
	input rdls_pkg::word_t                     v_result,
	input logic                                line_last,
	input logic                                saturated,
	input logic [rdls_pkg::APB_DATA_BITS-1:0]  prdata
);

	`RDLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`RDLS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(u_result) && $stable(v_result) && $stable(line_last) && $stable(saturated), "result changed while stalled")
	`RDLS_ASSERT_NOW(a_last_unsat, out_valid && line_last, !saturated, "line end result flagged as clamped")
	`RDLS_ASSERT_NOW(a_reg_width, 1'b1, prdata[rdls_pkg::APB_DATA_BITS-1] == 1'b0, "register read above 31 bits")

endmodule

bind reaction_diffusion_line_stencil_top rdls_checker u_rdls_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.u_result  (results.u_result),
	.v_result  (results.v_result),
	.line_last (results.line_last),
	.saturated (results.saturated),
	.prdata    (prdata)
);
